[hdl/mh64_pkg.sv]
package mh64_pkg;

    // Mixing multiplier and shift of the 64A variant.
    localparam logic [63:0] MixMul   = 64'hc6a4a7935bd1e995;
    localparam int          MixShift = 47;

    // Sequencer states of the hash engine.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISP,
        ST_SEED,
        ST_K1,
        ST_K2,
        ST_HMUL,
        ST_FIN,
        ST_EMIT
    } t_state;

    // Request from the sequencer to the shared multiplier.
    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } t_mul_req;

    // Response of the shared multiplier.
    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } t_mul_rsp;

    // The xor with a right shift that appears in both the word mix and the finish.
    function automatic logic [63:0] xor_shift(input logic [63:0] v);
        return v ^ (v >> MixShift);
    endfunction

endpackage

[hdl/mh64_in_if.sv]
interface mh64_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        first_word;
    logic        last_word;
    logic [31:0] total_length;

    modport source (
        output valid, data_word, valid_bytes, first_word, last_word, total_length,
        input  ready
    );
    modport sink (
        input  valid, data_word, valid_bytes, first_word, last_word, total_length,
        output ready
    );
endinterface

[hdl/mh64_out_if.sv]
interface mh64_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (
        output valid, hash_value,
        input  ready
    );
    modport sink (
        input  valid, hash_value,
        output ready
    );
endinterface

[hdl/mh64_mul.sv]
module mh64_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mh64_pkg::t_mul_req  i_req,
    output mh64_pkg::t_mul_rsp  o_rsp
);
    import mh64_pkg::*;

    // Multiplies a 64-bit operand by the mixing constant modulo 2^64.
    // One 32x32 product per cycle: low*low, then the two cross terms
    // that only reach the upper half of the result.
    logic [63:0] r_a;
    logic [63:0] r_acc;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;

    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;

    // Operand selection for the current partial product.
    always_comb begin
        unique case (r_step)
            2'd0: begin
                w_mul_a = r_a[31:0];
                w_mul_b = MixMul[31:0];
            end
            2'd1: begin
                w_mul_a = r_a[31:0];
                w_mul_b = MixMul[63:32];
            end
            default: begin
                w_mul_a = r_a[63:32];
                w_mul_b = MixMul[31:0];
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_step <= 2'd0;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

    // Operand capture and product accumulation.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.operand;
        end
        if (r_busy) begin
            if (r_step == 2'd0) begin
                r_acc <= w_prod;
            end else begin
                r_acc[63:32] <= r_acc[63:32] + w_prod[31:0];
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;

`ifndef SYNTH
    // A new multiply is only launched when the unit is free. The cycle that
    // reports a result may already launch the next multiply.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("multiply started while busy");

    // A launched multiply runs through its three steps and then reports its result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> ##2 (r_step == 2'd2) ##1 r_done)
        else $error("multiply latency broken");

    // The result flag is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("multiply result flag held");
`endif

endmodule

[hdl/murmur2_hash_64.sv]
// MurmurHash2 64A engine. Send a message as little-endian 64-bit words; the
// first word's request carries the total byte length and the last one yields
// the 64-bit hash on the output channel. Load the seed through i_seed_we while
// no message is in flight. All mixing runs through a single multiplier by the
// constant, built from one 32x32 product per cycle. A request is taken only
// in idle and runs its multiplies in turn before the next request can be
// taken: one for the length seed on a first word, three for a full word, one
// for a short word and one for the finish on a last word; a last word then
// waits in the emit state until the output register is free and hands the
// hash to it, and that register holds it while the next request runs.
module murmur2_hash_64 #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_seed_we,
    input  logic [63:0] i_seed_wdata,
    mh64_in_if.sink     i_in,
    mh64_out_if.source  o_out
);
    import mh64_pkg::*;

    // Length bits that take part, counted modulo 2^LENGTH_WIDTH.
    localparam logic [64:0] LenMaskW = (65'd1 << LENGTH_WIDTH) - 65'd1;
    localparam logic [31:0] LenMask  = LenMaskW[31:0];

    t_state      r_state;
    t_state      n_state;
    logic [63:0] r_seed;
    logic [63:0] r_hash;
    logic [63:0] r_word;
    logic [3:0]  r_cnt;
    logic        r_first;
    logic        r_last;
    logic [31:0] r_len;
    logic [63:0] r_res;
    logic        r_out_valid;
    logic [63:0] r_out_hash;

    t_mul_req    w_req;
    t_mul_rsp    w_rsp;
    logic        w_accept;
    logic        w_out_free;
    logic [63:0] w_h_disp;
    logic [63:0] w_tail;
    t_state      w_disp_state;
    logic [63:0] w_disp_opnd;

    mh64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Hash value seen when the word is dispatched: freshly seeded or carried.
    assign w_h_disp = (r_state == ST_SEED) ? (r_seed ^ w_rsp.product) : r_hash;

    // Keep only the valid bytes of a short word.
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_tail[b*8 +: 8] = (4'(b) < r_cnt) ? r_word[b*8 +: 8] : 8'd0;
        end
    end

    // Choose the work for this word once the hash is seeded.
    always_comb begin
        if (r_cnt == 4'd8) begin
            w_disp_state = ST_K1;
            w_disp_opnd  = r_word;
        end else if (r_cnt != 4'd0) begin
            w_disp_state = ST_HMUL;
            w_disp_opnd  = w_h_disp ^ w_tail;
        end else if (r_last) begin
            w_disp_state = ST_FIN;
            w_disp_opnd  = xor_shift(w_h_disp);
        end else begin
            w_disp_state = ST_IDLE;
            w_disp_opnd  = w_h_disp;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_DISP;
            ST_DISP: n_state = r_first ? ST_SEED : w_disp_state;
            ST_SEED: if (w_rsp.done) n_state = w_disp_state;
            ST_K1:   if (w_rsp.done) n_state = ST_K2;
            ST_K2:   if (w_rsp.done) n_state = ST_HMUL;
            ST_HMUL: if (w_rsp.done) n_state = r_last ? ST_FIN : ST_IDLE;
            ST_FIN:  if (w_rsp.done) n_state = ST_EMIT;
            ST_EMIT: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Multiplier launches and input ready.
    always_comb begin
        w_req.start   = 1'b0;
        w_req.operand = w_disp_opnd;
        i_in.ready    = (r_state == ST_IDLE);
        unique case (r_state)
            ST_DISP: begin
                w_req.start   = r_first || (w_disp_state != ST_IDLE);
                w_req.operand = r_first ? {32'd0, r_len} : w_disp_opnd;
            end
            ST_SEED: begin
                w_req.start = w_rsp.done && (w_disp_state != ST_IDLE);
            end
            ST_K1: begin
                w_req.start   = w_rsp.done;
                w_req.operand = xor_shift(w_rsp.product);
            end
            ST_K2: begin
                w_req.start   = w_rsp.done;
                w_req.operand = r_hash ^ w_rsp.product;
            end
            ST_HMUL: begin
                w_req.start   = w_rsp.done && r_last;
                w_req.operand = xor_shift(w_rsp.product);
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= 64'd0;
            r_hash      <= 64'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_seed_we) begin
                r_seed <= i_seed_wdata;
            end
            if (r_state == ST_SEED && w_rsp.done) begin
                r_hash <= r_seed ^ w_rsp.product;
            end else if (r_state == ST_HMUL && w_rsp.done) begin
                r_hash <= w_rsp.product;
            end
            if (r_state == ST_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word  <= i_in.data_word;
            r_cnt   <= (i_in.valid_bytes > 4'd8) ? 4'd8 : i_in.valid_bytes;
            r_first <= i_in.first_word;
            r_last  <= i_in.last_word;
            r_len   <= i_in.total_length & LenMask;
        end
        if (r_state == ST_FIN && w_rsp.done) begin
            r_res <= xor_shift(w_rsp.product);
        end
        if (r_state == ST_EMIT && w_out_free) begin
            r_out_hash <= r_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out_hash;

`ifndef SYNTH
    // Multiply results only arrive while the sequencer waits for one.
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == ST_SEED || r_state == ST_K1 || r_state == ST_K2
                        || r_state == ST_HMUL || r_state == ST_FIN))
        else $error("multiply result with no consumer");

    // An accepted request is dispatched in the following cycle.
    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_DISP))
        else $error("accepted request not dispatched");

    // Leaving the emit state always presents a result.
    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_out_free) |=> o_out.valid && (r_state == ST_IDLE))
        else $error("finished hash not presented");
`endif

endmodule

[bench/murmur2_hash_64_test.sv]
module murmur2_hash_64_test;

    // Mixing constants of the 64A hash, kept apart from the design's own copy.
    localparam logic [63:0] HASH_MUL   = 64'hc6a4a7935bd1e995;
    localparam int          HASH_SHIFT = 47;

    // Wait after the last result while the engine may still be busy: it covers
    // the longest request, a first and last full word, plus the hand-off.
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 300;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        first;
        logic        last;
        logic [31:0] total_len;
    } msg_word_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_seed_we;
    logic [63:0] i_seed_wdata;

    mh64_in_if  in_bus ();
    mh64_out_if out_bus ();

    murmur2_hash_64 u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_we    (i_seed_we),
        .i_seed_wdata (i_seed_wdata),
        .i_in         (in_bus),
        .o_out        (out_bus)
    );

    // Words waiting to be sent and hashes waiting to come back.
    msg_word_t   pending_words[$];
    logic [63:0] expected_hashes[$];

    // Our own copy of the seed register and of the hash in progress.
    logic [63:0] seed_copy;
    logic [63:0] chain_hash;

    msg_word_t   cur_word;
    logic [63:0] digest;
    logic [63:0] want_hash;
    int          mismatches;
    int          src_gap;
    int          sink_hold;
    bit          src_idle_on;
    bit          sink_idle_on;
    int          hold_requests;
    int          holds_started;

    always #6 i_clk = ~i_clk;

    // Advances the hash by one word and returns 1 with the finished hash when
    // the word closes a message.
    function automatic bit absorb_word(input msg_word_t w, output logic [63:0] fin);
        logic [63:0] h;
        logic [63:0] k;
        logic [63:0] mask;
        int unsigned nb;
        nb = (w.nbytes > 4'd8) ? 8 : w.nbytes;
        h = chain_hash;
        if (w.first) begin
            h = seed_copy ^ (64'(w.total_len) * HASH_MUL);
        end
        if (nb == 8) begin
            k = w.word * HASH_MUL;
            k = k ^ (k >> HASH_SHIFT);
            k = k * HASH_MUL;
            h = (h ^ k) * HASH_MUL;
        end else if (nb > 0) begin
            mask = (64'd1 << (nb * 8)) - 64'd1;
            h = (h ^ (w.word & mask)) * HASH_MUL;
        end
        chain_hash = h;
        fin = h ^ (h >> HASH_SHIFT);
        fin = fin * HASH_MUL;
        fin = fin ^ (fin >> HASH_SHIFT);
        return w.last;
    endfunction

    task automatic push_word(input logic [63:0] word, input logic [3:0] nbytes,
                             input logic first, input logic last,
                             input logic [31:0] total_len);
        msg_word_t w;
        w.word = word;
        w.nbytes = nbytes;
        w.first = first;
        w.last = last;
        w.total_len = total_len;
        pending_words.push_back(w);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Queues one message, mostly well formed, sometimes a stray word.
    task automatic queue_message(output int count);
        int nfull;
        int tail;
        int nwords;
        logic [31:0] len;
        count = 0;
        if ($urandom_range(0, 99) < 82) begin
            nfull = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
            tail = $urandom_range(0, 7);
            len = nfull * 8 + tail;
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom;
            end
            if (nfull == 0 && tail == 0) begin
                // Empty message.
                push_word(rand_word(), 4'd0, 1'b1, 1'b1, len);
                count = 1;
            end else begin
                nwords = nfull + ((tail != 0) ? 1 : 0);
                for (int i = 0; i < nfull; i++) begin
                    push_word(rand_word(), 4'd8, i == 0, i == nwords - 1, len);
                end
                if (tail != 0) begin
                    push_word(rand_word(), 4'(tail), nfull == 0, 1'b1, len);
                end
                count = nwords;
            end
        end else begin
            push_word(rand_word(), 4'($urandom_range(0, 15)), 1'($urandom),
                      1'($urandom), $urandom);
            count = 1;
        end
    endtask

    task automatic queue_random(input int target);
        int made;
        int n;
        made = 0;
        @(negedge i_clk);
        while (made < target) begin
            queue_message(n);
            made += n;
        end
    endtask

    // Waits until every word is sent and every hash is back, then lets the
    // engine finish any word that produces no hash.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_words.size() != 0 || in_bus.valid || expected_hashes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        @(posedge i_clk);
        i_seed_we <= 1'b1;
        i_seed_wdata <= value;
        seed_copy = value;
        @(posedge i_clk);
        i_seed_we <= 1'b0;
    endtask

    // Request driver: offers queued words, with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                if (absorb_word(cur_word, digest)) begin
                    expected_hashes.push_back(digest);
                end
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_bus.valid <= 1'b0;
                end else if (src_idle_on && pending_words.size() > 0
                             && $urandom_range(0, 15) == 0) begin
                    src_gap = $urandom_range(0, 10);
                    in_bus.valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    in_bus.valid <= 1'b1;
                    in_bus.data_word <= cur_word.word;
                    in_bus.valid_bytes <= cur_word.nbytes;
                    in_bus.first_word <= cur_word.first;
                    in_bus.last_word <= cur_word.last;
                    in_bus.total_length <= cur_word.total_len;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Hash monitor: checks each result and applies back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_hashes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected hash %h", out_bus.hash_value);
                    end
                end else begin
                    want_hash = expected_hashes.pop_front();
                    if (out_bus.hash_value !== want_hash) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("hash_value: expected %h, got %h",
                                     want_hash, out_bus.hash_value);
                        end
                    end
                end
            end
            if (hold_requests != holds_started) begin
                holds_started = hold_requests;
                sink_hold = LONG_HOLD;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                out_bus.ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 15) == 0) begin
                sink_hold = $urandom_range(0, 10);
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // Run limit.
    initial begin
        #(12 * 400000);
        $display("murmur2_hash_64_test NOT OK");
        $finish;
    end

    // Reset, seed settings and stimulus phases.
    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_seed_we = 1'b0;
        i_seed_wdata = '0;
        in_bus.valid = 1'b0;
        in_bus.data_word = '0;
        in_bus.valid_bytes = '0;
        in_bus.first_word = 1'b0;
        in_bus.last_word = 1'b0;
        in_bus.total_length = '0;
        out_bus.ready = 1'b0;
        seed_copy = '0;
        chain_hash = '0;
        mismatches = 0;
        src_gap = 0;
        sink_hold = 0;
        hold_requests = 0;
        holds_started = 0;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset seed.
        @(negedge i_clk);
        push_word(rand_word(), 4'd0, 1'b1, 1'b1, 32'd0);
        push_word({64{1'b1}}, 4'd8, 1'b1, 1'b1, 32'd8);
        push_word(64'd0, 4'd8, 1'b1, 1'b0, 32'hffffffff);
        push_word({64{1'b1}}, 4'd8, 1'b0, 1'b0, 32'd0);
        push_word(rand_word(), 4'd3, 1'b0, 1'b1, 32'd0);
        // More than eight valid bytes counts as a full word.
        push_word(rand_word(), 4'd15, 1'b1, 1'b1, 32'd8);
        // A short word in mid-message is folded in right away.
        push_word(rand_word(), 4'd5, 1'b1, 1'b0, 32'd13);
        push_word(rand_word(), 4'd8, 1'b0, 1'b1, 32'd0);
        // Words with no valid bytes, in the middle and at the end.
        push_word(rand_word(), 4'd8, 1'b1, 1'b0, 32'd16);
        push_word(rand_word(), 4'd0, 1'b0, 1'b0, 32'd0);
        push_word(rand_word(), 4'd0, 1'b0, 1'b1, 32'd0);
        // A closing word with no opening word carries on from the old hash.
        push_word(rand_word(), 4'd2, 1'b0, 1'b1, 32'd0);
        push_word(rand_word(), 4'd7, 1'b1, 1'b1, 32'd7);
        push_word(rand_word(), 4'd1, 1'b1, 1'b1, 32'd1);
        push_word(rand_word(), 4'd12, 1'b0, 1'b0, $urandom);
        push_word(rand_word(), 4'd9, 1'b1, 1'b1, 32'hffffffff);
        // An opening word in mid-message reseeds the hash.
        push_word({64{1'b1}}, 4'd4, 1'b1, 1'b0, 32'd20);
        push_word(rand_word(), 4'd8, 1'b1, 1'b1, 32'd8);
        push_word(rand_word(), 4'd6, 1'b1, 1'b0, 32'd5);
        push_word(rand_word(), 4'd8, 1'b0, 1'b1, 32'hffffffff);
        wait_drained();

        write_seed({64{1'b1}});
        queue_random(350);
        wait_drained();

        write_seed(64'd0);
        queue_random(350);
        wait_drained();

        // Long receiver stall while words keep coming.
        write_seed(rand_word());
        @(negedge i_clk);
        hold_requests++;
        queue_random(350);
        wait_drained();

        write_seed(64'h8000000000000001);
        queue_random(300);
        wait_drained();

        // Closing stretch at full rate on both sides.
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        write_seed(rand_word());
        queue_random(300);
        wait_drained();

        if (mismatches == 0 && expected_hashes.size() == 0) begin
            $display("murmur2_hash_64_test OK");
        end else begin
            $display("murmur2_hash_64_test NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
hdl/mh64_pkg.sv
hdl/mh64_in_if.sv
hdl/mh64_out_if.sv
hdl/mh64_mul.sv
hdl/murmur2_hash_64.sv
bench/murmur2_hash_64_test.sv
